FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the first-fit page allocator.
// No dependencies; the top level takes this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`define ASSERT_ALWAYS(label, clk_s, rst_s, expr) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) \
        else $error("invariant check failed");

`else

`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`define ASSERT_ALWAYS(label, clk_s, rst_s, expr)

`endif

`endif

FILE: src/ffpa_pkg.sv
// Package of the first-fit page allocator: widths, codes, state and
// control types. No dependencies.
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam int ADDR_W         = 48;
    localparam int FRAME_W        = 36;
    localparam int CNT_W          = 9;
    localparam int ENTRY_W        = CNT_W + 1;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int APB_DATA_W     = 64;
    localparam int APB_ADDR_W     = 4;
    localparam int DEF_MAX_PAGES  = 256;
    localparam int DEF_PAGE_SHIFT = 12;
    localparam logic [CNT_W-1:0] RESET_PAGES = CNT_W'(256);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_NOT_FREED  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_BASE_FRAME   = 1'b0,
        REG_PAGES_IN_USE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ALLOC_OK,
        RES_ZERO,
        RES_NO_FIT,
        RES_FREE_OK,
        RES_NOT_FREED
    } res_kind_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_DISPATCH,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_WR,
        S_WIPE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic      accept;
        logic      decode;
        logic      scan_start;
        logic      scan_step;
        logic      mark_step;
        logic      free_rd;
        logic      free_start;
        logic      free_step;
        logic      clr_step;
        logic      load_result;
        res_kind_t kind;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic need_zero;
        logic need_over;
        logic idx_out;
        logic scan_found;
        logic scan_fail;
        logic mark_last;
        logic len_zero;
        logic free_last;
        logic clr_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: src/ffpa_if.sv
// Request and response channel interfaces of the first-fit page allocator.
// Depends on ffpa_pkg for the field widths.
`timescale 1ns / 1ps

interface ffpa_req_if;
    import ffpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] size_bytes;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, output cmd, output size_bytes, output block_address,
                    input ready);
    modport sink (input valid, input cmd, input size_bytes, input block_address,
                  output ready);
endinterface

interface ffpa_rsp_if;
    import ffpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;
    logic [CNT_W-1:0]    block_pages;

    modport source (output valid, output status, output granted_address,
                    output block_pages, input ready);
    modport sink (input valid, input status, input granted_address, input block_pages,
                  output ready);
endinterface

FILE: src/first_fit_page_allocator.sv
// Top level of the first-fit contiguous page allocator.
// Depends on ffpa_pkg, ffpa_if, ffpa_regs, ffpa_ctrl, ffpa_dp, assert_macros.svh.
//
//   Channel  Direction  Handshake          Beat
//   req      in         valid / ready      cmd, size_bytes, block_address
//   rsp      out        valid / ready      status, granted_address, block_pages
//   apb      in         psel/penable/pwrite  paddr, pwdata, prdata
//
// One request at a time; the page map is a single-port-write memory read
// once per cycle. Allocate scans the map and then marks the granted pages;
// free reads the run head, checks its length and then clears the run.
// Reset and the clear command sweep the whole map, with req held off.
// A new request is taken while the previous response still waits on rsp.ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_fit_page_allocator #(
    parameter int MAX_PAGES  = ffpa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_SHIFT = ffpa_pkg::DEF_PAGE_SHIFT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ffpa_req_if.sink                           req,
    ffpa_rsp_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ffpa_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ffpa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ffpa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import ffpa_pkg::*;

    ctrl_cmd_t          ctl_cmd;
    ctrl_sts_t          ctl_sts;
    logic [FRAME_W-1:0] base_frame;
    logic [CNT_W-1:0]   pages_in_use;
    logic               req_ready;

    ffpa_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .base_frame   (base_frame),
        .pages_in_use (pages_in_use)
    );

    ffpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (ctl_sts),
        .ctl       (ctl_cmd)
    );

    ffpa_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_cmd),
        .sts          (ctl_sts),
        .in_cmd       (req.cmd),
        .in_size      (req.size_bytes),
        .in_addr      (req.block_address),
        .base_frame   (base_frame),
        .pages_in_use (pages_in_use),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_status   (rsp.status),
        .out_addr     (rsp.granted_address),
        .out_pages    (rsp.block_pages)
    );

    assign req.ready = req_ready;

    `ASSERT_ALWAYS(a_one_map_op, clk, rst_n, $onehot0({ctl_cmd.clr_step, ctl_cmd.scan_step, ctl_cmd.mark_step, ctl_cmd.free_step}))
    `ASSERT_IMPLIES(a_clear_holds_req, clk, rst_n, ctl_cmd.clr_step, !req.ready)
    `ASSERT_NEXT(a_load_shows_beat, clk, rst_n, ctl_cmd.load_result, rsp.valid)
    `ASSERT_IMPLIES(a_fail_is_empty, clk, rst_n, rsp.valid && (rsp.status == ST_NO_FIT), (rsp.granted_address == '0) && (rsp.block_pages == '0))

endmodule

FILE: src/ffpa_regs.sv
// APB configuration registers: region base frame and managed page count.
// Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ffpa_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ffpa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ffpa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [ffpa_pkg::FRAME_W-1:0]       base_frame,
    output logic [ffpa_pkg::CNT_W-1:0]         pages_in_use
);
    import ffpa_pkg::*;

    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;
    logic [CNT_W-1:0]   pages_reg;
    logic [CNT_W-1:0]   pages_next;
    logic               wr_en;
    reg_idx_t           sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = reg_idx_t'(paddr[3]);

    always_comb
    begin
        frame_next = frame_reg;
        pages_next = pages_reg;
        prdata     = '0;
        unique case (sel)
            REG_BASE_FRAME:
            begin
                prdata = APB_DATA_W'(frame_reg);
                if (wr_en)
                begin
                    frame_next = pwdata[FRAME_W-1:0];
                end
            end
            REG_PAGES_IN_USE:
            begin
                prdata = APB_DATA_W'(pages_reg);
                if (wr_en)
                begin
                    pages_next = pwdata[CNT_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            pages_reg <= RESET_PAGES;
        end
        else
        begin
            frame_reg <= frame_next;
            pages_reg <= pages_next;
        end
    end

    assign base_frame   = frame_reg;
    assign pages_in_use = pages_reg;

endmodule

FILE: src/ffpa_ctrl.sv
// Controller state machine of the first-fit page allocator: sequences
// decode, scan, marking, release and clearing. Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ffpa_pkg::ctrl_sts_t  sts,
    output ffpa_pkg::ctrl_cmd_t  ctl
);
    import ffpa_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    res_kind_t kind_reg;
    res_kind_t kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            kind_reg  <= RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        req_ready  = 1'b0;
        ctl        = '0;
        ctl.kind   = kind_reg;
        unique case (state_reg)
            S_INIT:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.decode = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (sts.cmd)
                    CMD_ALLOC:
                    begin
                        if (sts.need_zero)
                        begin
                            kind_next  = RES_ZERO;
                            state_next = S_DONE;
                        end
                        else if (sts.need_over)
                        begin
                            kind_next  = RES_NO_FIT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (sts.idx_out)
                        begin
                            kind_next  = RES_NOT_FREED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FREE_RD;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        kind_next  = RES_NONE;
                        state_next = S_WIPE;
                    end
                    CMD_UNUSED:
                    begin
                        kind_next  = RES_NONE;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_found)
                begin
                    kind_next  = RES_ALLOC_OK;
                    state_next = S_MARK;
                end
                else if (sts.scan_fail)
                begin
                    kind_next  = RES_NO_FIT;
                    state_next = S_DONE;
                end
            end
            S_MARK:
            begin
                ctl.mark_step = 1'b1;
                if (sts.mark_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE_RD:
            begin
                ctl.free_rd = 1'b1;
                state_next  = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                if (sts.len_zero)
                begin
                    kind_next  = RES_NOT_FREED;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.free_start = 1'b1;
                    kind_next      = RES_FREE_OK;
                    state_next     = S_FREE_WR;
                end
            end
            S_FREE_WR:
            begin
                ctl.free_step = 1'b1;
                if (sts.free_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_WIPE:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/ffpa_dp.sv
// Datapath of the first-fit page allocator: page map memory, run scan,
// address arithmetic and the response register. Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_dp #(
    parameter int MAX_PAGES  = ffpa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_SHIFT = ffpa_pkg::DEF_PAGE_SHIFT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ffpa_pkg::ctrl_cmd_t                ctl,
    output ffpa_pkg::ctrl_sts_t                sts,
    input  logic [ffpa_pkg::CMD_W-1:0]         in_cmd,
    input  logic [ffpa_pkg::ADDR_W-1:0]        in_size,
    input  logic [ffpa_pkg::ADDR_W-1:0]        in_addr,
    input  logic [ffpa_pkg::FRAME_W-1:0]       base_frame,
    input  logic [ffpa_pkg::CNT_W-1:0]         pages_in_use,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ffpa_pkg::STATUS_W-1:0]      out_status,
    output logic [ffpa_pkg::ADDR_W-1:0]        out_addr,
    output logic [ffpa_pkg::CNT_W-1:0]         out_pages
);
    import ffpa_pkg::*;

    localparam int AW     = $clog2(MAX_PAGES);
    localparam int PW     = ((AW > CNT_W + 1) ? AW : CNT_W + 1) + 1;
    localparam int NEED_W = ADDR_W + 1 - PAGE_SHIFT;
    localparam int IDX_W  = ADDR_W - PAGE_SHIFT;

    logic [ENTRY_W-1:0] mem [MAX_PAGES];
    logic [ENTRY_W-1:0] rd_data_reg;

    cmd_t               cmd_reg;
    logic [ADDR_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [PW-1:0]      scan_ptr_reg;
    logic               chk_vld_reg;
    logic [PW-1:0]      chk_idx_reg;
    logic [CNT_W-1:0]   run_reg;
    logic [PW-1:0]      start_reg;
    logic [PW-1:0]      wr_ptr_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic               first_reg;
    logic [CNT_W-1:0]   len_reg;
    logic [AW-1:0]      clr_ptr_reg;
    logic               out_vld_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [CNT_W-1:0]   out_pages_reg;

    logic [CNT_W-1:0]   count;
    logic [PW-1:0]      count_pw;
    logic [CNT_W-1:0]   need9;
    logic [CNT_W-1:0]   rd_len;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W:0]    size_up;
    logic [ADDR_W-1:0]  addr_diff;
    logic [ADDR_W-1:0]  granted_ok;
    logic               issue;
    logic [CNT_W-1:0]   run_new;
    logic               found;
    logic [PW-1:0]      start_calc;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    status_t            res_status;
    logic [ADDR_W-1:0]  res_addr;
    logic [CNT_W-1:0]   res_pages;

    assign count    = (32'(pages_in_use) > MAX_PAGES) ? CNT_W'(MAX_PAGES) : pages_in_use;
    assign count_pw = PW'(count);
    assign need9    = need_reg[CNT_W-1:0];
    assign rd_len   = rd_data_reg[ENTRY_W-1:1];
    assign base     = ADDR_W'({base_frame, {PAGE_SHIFT{1'b0}}});
    assign size_up  = {1'b0, size_reg}
                    + {{(ADDR_W + 1 - PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
    assign addr_diff  = addr_reg - base;
    assign granted_ok = base + (ADDR_W'(start_reg) << PAGE_SHIFT);

    assign issue      = ctl.scan_step && (scan_ptr_reg < count_pw);
    assign run_new    = (rd_data_reg == '0) ? run_reg + CNT_W'(1) : '0;
    assign found      = chk_vld_reg && (run_new == need9);
    assign start_calc = chk_idx_reg + PW'(1) - PW'(need9);

    assign sts.cmd        = cmd_reg;
    assign sts.need_zero  = (need_reg == '0);
    assign sts.need_over  = (need_reg > NEED_W'(count));
    assign sts.idx_out    = (idx_reg >= IDX_W'(count));
    assign sts.scan_found = found;
    assign sts.scan_fail  = chk_vld_reg && !found && (chk_idx_reg + PW'(1) == count_pw);
    assign sts.mark_last  = (rem_reg == CNT_W'(1));
    assign sts.len_zero   = (rd_len == '0);
    assign sts.free_last  = (rem_reg == CNT_W'(1)) || (32'(wr_ptr_reg) == MAX_PAGES - 1);
    assign sts.clr_last   = (clr_ptr_reg == AW'(MAX_PAGES - 1));
    assign sts.out_free   = !out_vld_reg || out_ready;

    always_comb
    begin
        wr_en   = ctl.clr_step || ctl.mark_step || ctl.free_step;
        wr_addr = ctl.clr_step ? clr_ptr_reg : AW'(wr_ptr_reg);
        wr_data = '0;
        if (ctl.mark_step)
        begin
            wr_data = first_reg ? {need9, 1'b1} : ENTRY_W'(1);
        end
        rd_en   = issue || ctl.free_rd;
        rd_addr = ctl.free_rd ? AW'(idx_reg) : AW'(scan_ptr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        res_status = ST_DONE;
        res_addr   = '0;
        res_pages  = '0;
        unique case (ctl.kind)
            RES_NONE:
            begin
                res_status = ST_DONE;
            end
            RES_ALLOC_OK:
            begin
                res_addr  = granted_ok;
                res_pages = need9;
            end
            RES_ZERO:
            begin
                res_addr = base;
            end
            RES_NO_FIT:
            begin
                res_status = ST_NO_FIT;
            end
            RES_FREE_OK:
            begin
                res_pages = len_reg;
            end
            RES_NOT_FREED:
            begin
                res_status = ST_NOT_FREED;
            end
            default:
            begin
                res_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_vld_reg <= 1'b0;
            clr_ptr_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.scan_start)
            begin
                chk_vld_reg <= 1'b0;
            end
            else if (ctl.scan_step)
            begin
                chk_vld_reg <= issue;
            end
            if (ctl.clr_step)
            begin
                clr_ptr_reg <= sts.clr_last ? '0 : clr_ptr_reg + AW'(1);
            end
            if (ctl.load_result)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= cmd_t'(in_cmd);
            size_reg <= in_size;
            addr_reg <= in_addr;
        end
        if (ctl.decode)
        begin
            need_reg <= size_up[ADDR_W:PAGE_SHIFT];
            idx_reg  <= addr_diff[ADDR_W-1:PAGE_SHIFT];
        end
        if (ctl.scan_start)
        begin
            scan_ptr_reg <= '0;
            run_reg      <= '0;
        end
        else if (ctl.scan_step)
        begin
            if (issue)
            begin
                scan_ptr_reg <= scan_ptr_reg + PW'(1);
            end
            chk_idx_reg <= scan_ptr_reg;
            if (chk_vld_reg)
            begin
                run_reg <= run_new;
            end
            if (found)
            begin
                start_reg  <= start_calc;
                wr_ptr_reg <= start_calc;
                rem_reg    <= need9;
                first_reg  <= 1'b1;
            end
        end
        if (ctl.free_start)
        begin
            wr_ptr_reg <= PW'(idx_reg);
            rem_reg    <= rd_len;
            len_reg    <= rd_len;
        end
        if (ctl.mark_step || ctl.free_step)
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(1);
            rem_reg    <= rem_reg - CNT_W'(1);
            first_reg  <= 1'b0;
        end
        if (ctl.load_result)
        begin
            out_status_reg <= res_status;
            out_addr_reg   <= res_addr;
            out_pages_reg  <= res_pages;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_addr   = out_addr_reg;
    assign out_pages  = out_pages_reg;

endmodule

FILE: dv/first_fit_page_allocator_test.sv
// Self-checking testbench of the first-fit page allocator: directed corner cases,
// then random allocate/free traffic under several region settings, with idling on both sides.
// Depends on ffpa_pkg, ffpa_if and the first_fit_page_allocator RTL.
`timescale 1ns / 1ps

module first_fit_page_allocator_test;
    import ffpa_pkg::*;

    localparam int          PAGE_SHIFT    = DEF_PAGE_SHIFT;
    localparam int          MAX_PAGES     = DEF_MAX_PAGES;
    localparam logic [63:0] ADDR_MASK     = 64'hFFFF_FFFF_FFFF;
    localparam int          QUIET_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 600;
    localparam int          SWEEP_CYCLES  = 300;

    typedef struct {
        status_t           status;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  block_pages;
    } outcome_t;

    class alloc_scoreboard;
        logic [ENTRY_W-1:0] page_table [MAX_PAGES];
        logic [FRAME_W-1:0] base_frame;
        logic [CNT_W-1:0]   region_pages;
        outcome_t           pending_outcomes [$];
        int                 errors;
        int                 checked;
        int                 grants;
        int                 releases;
        int                 refusals;

        function new();
            base_frame   = '0;
            region_pages = RESET_PAGES;
            foreach (page_table[i])
                page_table[i] = '0;
            errors   = 0;
            checked  = 0;
            grants   = 0;
            releases = 0;
            refusals = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_BASE_FRAME)
                base_frame = value[FRAME_W-1:0];
            else
                region_pages = value[CNT_W-1:0];
        endfunction

        function longint unsigned managed_count();
            return (region_pages > MAX_PAGES) ? MAX_PAGES : region_pages;
        endfunction

        function logic [63:0] base_address();
            return ({28'b0, base_frame} << PAGE_SHIFT) & ADDR_MASK;
        endfunction

        function int pick_run_start();
            int starts [$];
            foreach (page_table[i])
                if (page_table[i][ENTRY_W-1:1] != '0)
                    starts.push_back(i);
            if (starts.size() == 0)
                return -1;
            return starts[$urandom_range(0, starts.size() - 1)];
        endfunction

        function void note_request(cmd_t cmd, logic [ADDR_W-1:0] size,
                                   logic [ADDR_W-1:0] addr);
            outcome_t          want;
            longint unsigned   count;
            longint unsigned   need;
            longint unsigned   run;
            longint unsigned   start;
            longint unsigned   p;
            longint unsigned   len;
            logic [63:0]       idx;
            bit                found;
            want.status          = ST_DONE;
            want.granted_address = '0;
            want.block_pages     = '0;
            count = managed_count();
            case (cmd)
                CMD_ALLOC:
                begin
                    need = ({16'b0, size} + 64'hFFF) >> PAGE_SHIFT;
                    if (need == 0)
                        want.granted_address = ADDR_W'(base_address());
                    else if (need > count)
                        want.status = ST_NO_FIT;
                    else
                    begin
                        run   = 0;
                        start = 0;
                        found = 1'b0;
                        p     = 0;
                        while (p < count && !found)
                        begin
                            run = (page_table[p] == '0) ? run + 1 : 0;
                            if (run == need)
                            begin
                                start = p + 1 - need;
                                found = 1'b1;
                            end
                            p++;
                        end
                        if (found)
                        begin
                            for (p = start; p < start + need; p++)
                                page_table[p] = ENTRY_W'(1);
                            page_table[start] = ENTRY_W'((need << 1) | 1);
                            want.granted_address =
                                ADDR_W'(base_address() + (start << PAGE_SHIFT));
                            want.block_pages = CNT_W'(need);
                            grants++;
                        end
                        else
                            want.status = ST_NO_FIT;
                    end
                end
                CMD_FREE:
                begin
                    idx = (({16'b0, addr} - base_address()) & ADDR_MASK) >> PAGE_SHIFT;
                    if (idx >= count)
                        want.status = ST_NOT_FREED;
                    else
                    begin
                        len = page_table[idx][ENTRY_W-1:1];
                        if (len == 0)
                            want.status = ST_NOT_FREED;
                        else
                        begin
                            p = idx;
                            while (p < idx + len && p < MAX_PAGES)
                            begin
                                page_table[p] = '0;
                                p++;
                            end
                            want.block_pages = CNT_W'(len);
                            releases++;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    foreach (page_table[i])
                        page_table[i] = '0;
                end
                default:
                begin
                end
            endcase
            if (want.status != ST_DONE)
                refusals++;
            pending_outcomes.push_back(want);
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t ns: response %0d, %s is 0x%0h, expected 0x%0h",
                     $time, checked, field, got, want);
        endtask

        task check_response(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] granted,
                            logic [CNT_W-1:0] pages);
            outcome_t want;
            if (pending_outcomes.size() == 0)
                report_mismatch("unrequested beat, status", status, 0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (granted !== want.granted_address)
                    report_mismatch("granted_address", granted, want.granted_address);
                if (pages !== want.block_pages)
                    report_mismatch("block_pages", pages, want.block_pages);
            end
            checked++;
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    bit                    steady;
    int                    sent;
    int                    settings;
    alloc_scoreboard       sb;

    ffpa_req_if req_ch ();
    ffpa_rsp_if rsp_ch ();

    first_fit_page_allocator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.granted_address,
                                  rsp_ch.block_pages);
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 16);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("No beat moved for %0d cycles; the run is stuck.", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_request(cmd_t cmd, logic [ADDR_W-1:0] size,
                                logic [ADDR_W-1:0] addr);
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.size_bytes    <= size;
        req_ch.block_address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(cmd, size, addr);
        sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(logic [FRAME_W-1:0] frame, logic [CNT_W-1:0] count);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        wait_drained();
        // The block sits idle for a while before the register writes.
        repeat (SWEEP_CYCLES)
            @(posedge clk);
        write_register(REG_BASE_FRAME, {noise[63:FRAME_W], frame});
        write_register(REG_PAGES_IN_USE, {noise[63:CNT_W], count});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings++;
    endtask

    task automatic send_random_request();
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;
        longint unsigned   count;
        longint unsigned   need;
        int                pick;
        int                start;
        cmd_t              cmd;
        size  = ADDR_W'({$urandom, $urandom});
        addr  = ADDR_W'({$urandom, $urandom});
        base  = ADDR_W'(sb.base_address());
        count = sb.managed_count();
        pick  = $urandom_range(0, 99);
        if (pick < 50)
        begin
            cmd  = CMD_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                size = '0;
            else if (pick >= 10)
            begin
                if (pick < 18)
                    need = $urandom_range(1, count + 1);
                else
                    need = $urandom_range(1, 8);
                size = ADDR_W'(((need - 1) << PAGE_SHIFT) + $urandom_range(1, 4096));
            end
        end
        else if (pick < 90)
        begin
            cmd   = CMD_FREE;
            pick  = $urandom_range(0, 99);
            start = sb.pick_run_start();
            if (pick < 70 && start >= 0)
                addr = base + ADDR_W'(start << PAGE_SHIFT) + ADDR_W'($urandom_range(0, 4095));
            else if (pick < 82)
                addr = base + ADDR_W'($urandom_range(0, MAX_PAGES - 1) << PAGE_SHIFT);
            else if (pick >= 92)
                addr = base + ADDR_W'((count + $urandom_range(0, 300)) << PAGE_SHIFT);
        end
        else if (pick < 94)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_UNUSED;
        send_request(cmd, size, addr);
    endtask

    task automatic run_random(int n);
        repeat (n)
            send_random_request();
    endtask

    task automatic run_directed();
        send_request(CMD_ALLOC, '0, '0);
        send_request(CMD_ALLOC, 48'h1, '0);
        send_request(CMD_ALLOC, 48'h1000, '0);
        send_request(CMD_ALLOC, 48'h1001, '0);
        send_request(CMD_ALLOC, '1, '1);
        send_request(CMD_FREE, '1, 48'h3000);
        send_request(CMD_FREE, '0, 48'h64000);
        send_request(CMD_FREE, '0, '1);
        send_request(CMD_FREE, '0, 48'h2ABC);
        send_request(CMD_UNUSED, '1, '1);
        send_request(CMD_ALLOC, 48'h100000, '0);
        send_request(CMD_CLEAR, '1, '1);
        send_request(CMD_ALLOC, 48'h100000, '0);
        send_request(CMD_ALLOC, 48'h1, '0);
        send_request(CMD_FREE, '0, 48'h0);
        send_request(CMD_ALLOC, 48'h100001, '0);
        send_request(CMD_ALLOC, 48'h0FF001, '0);
        send_request(CMD_FREE, '0, 48'h0FFF);
        send_request(CMD_CLEAR, '0, '0);
    endtask

    initial
    begin
        sb                   = new();
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.cmd           <= CMD_ALLOC;
        req_ch.size_bytes    <= '0;
        req_ch.block_address <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        configure(36'hF_FFFF_FFFF, 9'd511);
        run_random(200);
        steady = 1'b1;
        configure(FRAME_W'({$urandom, $urandom}), 9'd256);
        run_random(250);
        steady = 1'b0;
        configure(FRAME_W'({$urandom, $urandom}), 9'd24);
        run_random(250);
        configure('0, 9'd1);
        run_random(100);
        configure(FRAME_W'({$urandom, $urandom}), 9'd0);
        run_random(60);
        configure(FRAME_W'({$urandom, $urandom}), CNT_W'($urandom_range(2, 255)));
        run_random(290);

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        $display("Sent %0d requests under %0d region settings, page counts 0 to above depth.",
                 sent, settings);
        $display("Checked %0d responses: %0d grants, %0d releases, %0d refused requests.",
                 sb.checked, sb.grants, sb.releases, sb.refusals);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/ffpa_pkg.sv
src/ffpa_if.sv
src/ffpa_regs.sv
src/ffpa_ctrl.sv
src/ffpa_dp.sv
src/first_fit_page_allocator.sv
dv/first_fit_page_allocator_test.sv
